// ===== hw/rtl/gbalu_pkg.sv =====
// Package for the handheld-console CPU ALU: field widths, operation codes
// and flag bit positions. Used by the channel interfaces and the top level.
package gbalu_pkg;

   localparam int FUNC_WIDTH  = 5;
   localparam int BYTE_WIDTH  = 8;
   localparam int WORD_WIDTH  = 16;
   localparam int INDEX_WIDTH = 3;
   localparam int FLAG_WIDTH  = 4;

   // Positions of the flags within a flag nibble.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Largest value in the packed-BCD range and the DAA corrections.
   localparam logic [BYTE_WIDTH-1:0] DAA_MAX_BCD   = 8'h99;
   localparam logic [BYTE_WIDTH-1:0] DAA_HIGH_FIX  = 8'h60;
   localparam logic [BYTE_WIDTH-1:0] DAA_LOW_FIX   = 8'h06;
   localparam logic [3:0]            DAA_MAX_DIGIT = 4'h9;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FN_ADD   = 5'd0,
      FN_ADC   = 5'd1,
      FN_SUB   = 5'd2,
      FN_SBC   = 5'd3,
      FN_AND   = 5'd4,
      FN_XOR   = 5'd5,
      FN_OR    = 5'd6,
      FN_CP    = 5'd7,
      FN_DAA   = 5'd8,
      FN_INC   = 5'd9,
      FN_DEC   = 5'd10,
      FN_RLC   = 5'd11,
      FN_RRC   = 5'd12,
      FN_RL    = 5'd13,
      FN_RR    = 5'd14,
      FN_SLA   = 5'd15,
      FN_SRA   = 5'd16,
      FN_SRL   = 5'd17,
      FN_SWAP  = 5'd18,
      FN_BIT   = 5'd19,
      FN_RES   = 5'd20,
      FN_SET   = 5'd21,
      FN_ADD16 = 5'd22,
      FN_INC16 = 5'd23,
      FN_DEC16 = 5'd24
   } func_type;

endpackage

// ===== hw/rtl/gbalu_req_if.sv =====
// Request channel of the ALU: valid/ready handshake plus the operands.
// Depends on gbalu_pkg for the field widths.
interface gbalu_req_if import gbalu_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FUNC_WIDTH-1:0]  func;
   logic [BYTE_WIDTH-1:0]  operand_a;
   logic [BYTE_WIDTH-1:0]  operand_b;
   logic [INDEX_WIDTH-1:0] bit_index;
   logic [WORD_WIDTH-1:0]  word_a;
   logic [WORD_WIDTH-1:0]  word_b;
   logic [FLAG_WIDTH-1:0]  flags_in;

   modport source (
      output valid, func, operand_a, operand_b, bit_index, word_a, word_b, flags_in,
      input  ready
   );
   modport sink (
      input  valid, func, operand_a, operand_b, bit_index, word_a, word_b, flags_in,
      output ready
   );
endinterface

// ===== hw/rtl/gbalu_rsp_if.sv =====
// Response channel of the ALU: valid/ready handshake plus the results.
// Depends on gbalu_pkg for the field widths.
interface gbalu_rsp_if import gbalu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] byte_result;
   logic [WORD_WIDTH-1:0] word_result;
   logic [FLAG_WIDTH-1:0] flags_out;
   logic                  write_back;

   modport source (
      output valid, byte_result, word_result, flags_out, write_back,
      input  ready
   );
   modport sink (
      input  valid, byte_result, word_result, flags_out, write_back,
      output ready
   );
endinterface

// ===== hw/rtl/gameboy_cpu_alu_top.sv =====
// Top level of the handheld-console CPU ALU (SM83 instruction set).
// Depends on gbalu_pkg, gbalu_req_if and gbalu_rsp_if.
//
// Usage: the execution stage offers one item on the req channel (operation
// code, two byte operands, a bit index, two 16-bit words and the incoming
// Z/N/H/C flags). The block answers with exactly one item on the rsp
// channel: the new byte, the new word, the new flags and a write-back mark,
// which is low for CP, BIT and unused operation codes.
// From acceptance to the result being offered, the item is captured in an
// input register, passes through the ALU logic and its answer is stored
// in the result register.
// Throughput is one item per cycle unless the receiver stalls; each item
// takes one pass through the ALU logic between the two registers, and
// req.ready stays high while the result register is empty or being taken.
// When the receiver stalls, the result holds, the input register fills and
// then req.ready drops; nothing is lost or repeated.
// Reset (synchronous, active high) empties both registers; there is no
// other state and no configuration.
module gameboy_cpu_alu_top import gbalu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gbalu_req_if.sink   req,
   gbalu_rsp_if.source rsp
);

   // Input register.
   logic                   s1_valid_ff, s1_valid_in;
   logic [FUNC_WIDTH-1:0]  func_ff;
   logic [BYTE_WIDTH-1:0]  operand_a_ff;
   logic [BYTE_WIDTH-1:0]  operand_b_ff;
   logic [INDEX_WIDTH-1:0] bit_index_ff;
   logic [WORD_WIDTH-1:0]  word_a_ff;
   logic [WORD_WIDTH-1:0]  word_b_ff;
   logic [FLAG_WIDTH-1:0]  flags_ff;

   // Result register.
   logic                   out_valid_ff, out_valid_in;
   logic [BYTE_WIDTH-1:0]  byte_ff, byte_in;
   logic [WORD_WIDTH-1:0]  word_ff, word_in;
   logic [FLAG_WIDTH-1:0]  flags_out_ff, flags_out_in;
   logic                   write_back_ff, write_back_in;

   logic out_free;
   logic out_load;
   logic req_take;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign out_load  = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff      <= req.func;
         operand_a_ff <= req.operand_a;
         operand_b_ff <= req.operand_b;
         bit_index_ff <= req.bit_index;
         word_a_ff    <= req.word_a;
         word_b_ff    <= req.word_b;
         flags_ff     <= req.flags_in;
      end
      if (out_load) begin
         byte_ff       <= byte_in;
         word_ff       <= word_in;
         flags_out_ff  <= flags_out_in;
         write_back_ff <= write_back_in;
      end
   end

   // ALU logic between the two registers.
   logic                  cin;
   logic                  carry_use;
   logic [BYTE_WIDTH:0]   sum9;
   logic [4:0]            half_sum;
   logic [BYTE_WIDTH:0]   diff9;
   logic [4:0]            half_diff;
   logic [BYTE_WIDTH-1:0] bit_mask;
   logic [BYTE_WIDTH-1:0] daa_value;
   logic                  daa_carry;
   logic [WORD_WIDTH:0]   sum17;
   logic [12:0]           half_sum13;
   logic [BYTE_WIDTH-1:0] r;
   logic [FLAG_WIDTH-1:0] f;

   assign cin       = flags_ff[FLAG_C];
   assign carry_use = (func_ff == FN_ADC || func_ff == FN_SBC) ? cin : 1'b0;
   assign sum9      = {1'b0, operand_a_ff} + {1'b0, operand_b_ff}
                      + {{BYTE_WIDTH{1'b0}}, carry_use};
   assign half_sum  = {1'b0, operand_a_ff[3:0]} + {1'b0, operand_b_ff[3:0]}
                      + {4'd0, carry_use};
   // The top bit of each difference is the borrow out of that width.
   assign diff9     = {1'b0, operand_a_ff} - {1'b0, operand_b_ff}
                      - {{BYTE_WIDTH{1'b0}}, carry_use};
   assign half_diff = {1'b0, operand_a_ff[3:0]} - {1'b0, operand_b_ff[3:0]}
                      - {4'd0, carry_use};
   assign bit_mask  = BYTE_WIDTH'(1) << bit_index_ff;
   assign sum17     = {1'b0, word_a_ff} + {1'b0, word_b_ff};
   assign half_sum13 = {1'b0, word_a_ff[11:0]} + {1'b0, word_b_ff[11:0]};

   // Decimal adjust: the high correction is decided on the original value,
   // the low one on the low digit, which the high correction leaves alone.
   always_comb begin
      daa_value = operand_a_ff;
      daa_carry = cin;
      if (!flags_ff[FLAG_N]) begin
         if (cin || operand_a_ff > DAA_MAX_BCD) begin
            daa_value = daa_value + DAA_HIGH_FIX;
            daa_carry = 1'b1;
         end
         if (flags_ff[FLAG_H] || daa_value[3:0] > DAA_MAX_DIGIT) begin
            daa_value = daa_value + DAA_LOW_FIX;
         end
      end else begin
         if (cin) begin
            daa_value = daa_value - DAA_HIGH_FIX;
         end
         if (flags_ff[FLAG_H]) begin
            daa_value = daa_value - DAA_LOW_FIX;
         end
      end
   end

   always_comb begin
      r             = operand_a_ff;
      f             = flags_ff;
      word_in       = '0;
      write_back_in = 1'b1;
      unique case (func_type'(func_ff))
         FN_ADD, FN_ADC: begin
            r = sum9[BYTE_WIDTH-1:0];
            f = '0;
            f[FLAG_H] = half_sum[4];
            f[FLAG_C] = sum9[BYTE_WIDTH];
         end
         FN_SUB, FN_SBC, FN_CP: begin
            r = diff9[BYTE_WIDTH-1:0];
            f = '0;
            f[FLAG_N] = 1'b1;
            f[FLAG_H] = half_diff[4];
            f[FLAG_C] = diff9[BYTE_WIDTH];
         end
         FN_AND: begin
            r = operand_a_ff & operand_b_ff;
            f = '0;
            f[FLAG_H] = 1'b1;
         end
         FN_XOR: begin
            r = operand_a_ff ^ operand_b_ff;
            f = '0;
         end
         FN_OR: begin
            r = operand_a_ff | operand_b_ff;
            f = '0;
         end
         FN_DAA: begin
            r = daa_value;
            f = '0;
            f[FLAG_N] = flags_ff[FLAG_N];
            f[FLAG_C] = daa_carry;
         end
         FN_INC: begin
            r = operand_a_ff + BYTE_WIDTH'(1);
            f = '0;
            f[FLAG_H] = (operand_a_ff[3:0] == 4'hF);
            f[FLAG_C] = cin;
         end
         FN_DEC: begin
            r = operand_a_ff - BYTE_WIDTH'(1);
            f = '0;
            f[FLAG_N] = 1'b1;
            f[FLAG_H] = (operand_a_ff[3:0] == 4'h0);
            f[FLAG_C] = cin;
         end
         FN_RLC: begin
            r = {operand_a_ff[6:0], operand_a_ff[7]};
            f = '0;
            f[FLAG_C] = operand_a_ff[7];
         end
         FN_RRC: begin
            r = {operand_a_ff[0], operand_a_ff[7:1]};
            f = '0;
            f[FLAG_C] = operand_a_ff[0];
         end
         FN_RL: begin
            r = {operand_a_ff[6:0], cin};
            f = '0;
            f[FLAG_C] = operand_a_ff[7];
         end
         FN_RR: begin
            r = {cin, operand_a_ff[7:1]};
            f = '0;
            f[FLAG_C] = operand_a_ff[0];
         end
         FN_SLA: begin
            r = {operand_a_ff[6:0], 1'b0};
            f = '0;
            f[FLAG_C] = operand_a_ff[7];
         end
         FN_SRA: begin
            r = {operand_a_ff[7], operand_a_ff[7:1]};
            f = '0;
            f[FLAG_C] = operand_a_ff[0];
         end
         FN_SRL: begin
            r = {1'b0, operand_a_ff[7:1]};
            f = '0;
            f[FLAG_C] = operand_a_ff[0];
         end
         FN_SWAP: begin
            r = {operand_a_ff[3:0], operand_a_ff[7:4]};
            f = '0;
         end
         FN_BIT: begin
            f = '0;
            f[FLAG_H] = 1'b1;
            f[FLAG_C] = cin;
            write_back_in = 1'b0;
         end
         FN_RES: begin
            r = operand_a_ff & ~bit_mask;
         end
         FN_SET: begin
            r = operand_a_ff | bit_mask;
         end
         FN_ADD16: begin
            r = '0;
            word_in = sum17[WORD_WIDTH-1:0];
            f = '0;
            f[FLAG_Z] = flags_ff[FLAG_Z];
            f[FLAG_H] = half_sum13[12];
            f[FLAG_C] = sum17[WORD_WIDTH];
         end
         FN_INC16: begin
            r = '0;
            word_in = word_a_ff + WORD_WIDTH'(1);
         end
         FN_DEC16: begin
            r = '0;
            word_in = word_a_ff - WORD_WIDTH'(1);
         end
         default: begin
            // Unused operation codes leave everything as it was.
            write_back_in = 1'b0;
         end
      endcase

      // Z follows the byte result for every byte operation that defines it.
      case (func_type'(func_ff))
         FN_ADD, FN_ADC, FN_SUB, FN_SBC, FN_AND, FN_XOR, FN_OR, FN_CP, FN_DAA,
         FN_INC, FN_DEC, FN_RLC, FN_RRC, FN_RL, FN_RR, FN_SLA, FN_SRA, FN_SRL,
         FN_SWAP: begin
            f[FLAG_Z] = (r == '0);
         end
         FN_BIT: begin
            f[FLAG_Z] = !operand_a_ff[bit_index_ff];
         end
         default: begin
         end
      endcase

      // A compare reports the flags of the subtraction but keeps the byte.
      if (func_ff == FN_CP) begin
         r = operand_a_ff;
         write_back_in = 1'b0;
      end

      byte_in      = r;
      flags_out_in = f;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.byte_result = byte_ff;
   assign rsp.word_result = word_ff;
   assign rsp.flags_out   = flags_out_ff;
   assign rsp.write_back  = write_back_ff;

`ifndef SYNTHESIS
   // An accepted item always occupies the input register in the next cycle.
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted item did not reach the input register");

   // A waiting item in the input register is never dropped while blocked.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(func_ff))
      else $error("blocked item left the input register");

   // 16-bit operations always write back and clear the byte result.
   a_word_ops: assert property (@(posedge clock) disable iff (reset)
      out_load && (func_ff == FN_ADD16 || func_ff == FN_INC16 || func_ff == FN_DEC16)
      |=> rsp.valid && rsp.write_back && rsp.byte_result == '0)
      else $error("16-bit operation produced a wrong result shape");
`endif

endmodule
